### hdl/phfu_pkg.sv
// Shared types, field layout and constants for the pipeline hazard forwarding unit.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package phfu_pkg;

    localparam int ADDR_W         = 48;
    localparam int REG_W          = 10;
    localparam int CYC_W          = 64;
    localparam int RING_DEPTH_DEF = 4;

    // Configuration port
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

    // Input beat layout
    localparam int S_TDATA_W  = 80;
    localparam int S_TUSER_W  = 3;
    localparam int S_ADDR_LSB = 0;
    localparam int S_SRCA_LSB = 48;
    localparam int S_SRCB_LSB = 58;
    localparam int S_DEST_LSB = 68;
    localparam int S_BR_BIT   = 0;
    localparam int S_LD_BIT   = 1;
    localparam int S_ST_BIT   = 2;

    // Result beat layout
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 2;
    localparam int M_CYC_LSB   = 0;
    localparam int M_DSTL_LSB  = 64;
    localparam int M_CSTL_LSB  = 66;
    localparam int M_FWD_BIT   = 68;
    localparam int M_LU_BIT    = 69;
    localparam int M_PATH_LSB  = 70;
    localparam int M_PAD_LSB   = 75;
    localparam int M_ACC_BIT   = 0;
    localparam int M_MEM_BIT   = 1;

    // Forwarding path bits
    localparam logic [4:0] PATH_EX_EX   = 5'h01;
    localparam logic [4:0] PATH_MEM_EX  = 5'h02;
    localparam logic [4:0] PATH_MEM_MEM = 5'h04;
    localparam logic [4:0] PATH_EX_MEM  = 5'h08;
    localparam logic [4:0] PATH_BRANCH  = 5'h10;

    localparam logic [1:0] STALL_NONE     = 2'd0;
    localparam logic [1:0] STALL_ONE      = 2'd1;
    localparam logic [1:0] STALL_MAX      = 2'd2;
    localparam logic [1:0] BRANCH_PENALTY = 2'd2;

    // One in-flight writer held by a cell
    typedef struct packed {
        logic             valid;
        logic [REG_W-1:0] dest;
        logic             is_load;
        logic [CYC_W-1:0] ex_ready;
        logic [CYC_W-1:0] mem_ready;
    } entry_t;

    // What one cell reports for one source register
    typedef struct packed {
        logic hit;
        logic is_load;
        logic mem_ok;    // MEM/WB result available now
        logic ex_ok;     // EX/MEM result available now
        logic one_left;  // MEM/WB result arrives next cycle
    } probe_t;

    // Resolution of one source register
    typedef struct packed {
        logic       hit;
        logic       is_load;
        logic [4:0] path;
        logic [1:0] stall;
    } src_res_t;

endpackage

### hdl/phfu_cell.sv
// One writer slot of the in-flight chain: holds an entry, passes it to the older
// neighbor on a push, and probes both source registers. Uses phfu_pkg.
`timescale 1ns / 1ps

module phfu_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           shift_en,
    input  phfu_pkg::entry_t               entry_in,
    input  logic [phfu_pkg::CYC_W-1:0]     cnt_p1,
    input  logic [phfu_pkg::CYC_W-1:0]     cnt_p2,
    input  logic [phfu_pkg::REG_W-1:0]     src_a,
    input  logic [phfu_pkg::REG_W-1:0]     src_b,
    output phfu_pkg::entry_t               entry_out,
    output phfu_pkg::probe_t               probe_a,
    output phfu_pkg::probe_t               probe_b
);
    import phfu_pkg::*;

    logic             valid_reg;
    logic [REG_W-1:0] dest_reg;
    logic             load_reg;
    logic [CYC_W-1:0] ex_reg;
    logic [CYC_W-1:0] mem_reg;
    logic             mem_ok;
    logic             ex_ok;
    logic             one_left;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= entry_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            dest_reg <= entry_in.dest;
            load_reg <= entry_in.is_load;
            ex_reg   <= entry_in.ex_ready;
            mem_reg  <= entry_in.mem_ready;
        end
    end

    assign entry_out = '{valid: valid_reg, dest: dest_reg, is_load: load_reg,
                         ex_ready: ex_reg, mem_ready: mem_reg};

    // Ready checks are shared by both sources
    assign mem_ok   = (mem_reg <= cnt_p1);
    assign ex_ok    = (ex_reg <= cnt_p1);
    assign one_left = (mem_reg == cnt_p2);

    assign probe_a = '{hit: valid_reg && (src_a != '0) && (dest_reg == src_a),
                       is_load: load_reg, mem_ok: mem_ok, ex_ok: ex_ok,
                       one_left: one_left};
    assign probe_b = '{hit: valid_reg && (src_b != '0) && (dest_reg == src_b),
                       is_load: load_reg, mem_ok: mem_ok, ex_ok: ex_ok,
                       one_left: one_left};

endmodule

### hdl/phfu_pick.sv
// Priority pick of the youngest matching cell for one source register and its
// forwarding path or stall. Uses phfu_pkg.
`timescale 1ns / 1ps

module phfu_pick #(
    parameter int DEPTH = phfu_pkg::RING_DEPTH_DEF
) (
    input  phfu_pkg::probe_t [DEPTH-1:0] probes,
    input  logic                         is_store,
    output phfu_pkg::src_res_t           res
);
    import phfu_pkg::*;

    probe_t sel;

    // Cell 0 is youngest: scan oldest first so the youngest hit wins
    always_comb begin
        sel = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (probes[i].hit) begin
                sel = probes[i];
            end
        end
    end

    always_comb begin
        res         = '0;
        res.hit     = sel.hit;
        res.is_load = sel.is_load;
        if (sel.hit) begin
            if (sel.mem_ok) begin
                res.path = is_store ? PATH_MEM_MEM : PATH_MEM_EX;
            end else if (sel.ex_ok && !sel.is_load) begin
                res.path = is_store ? PATH_EX_MEM : PATH_EX_EX;
            end else begin
                res.stall = sel.one_left ? STALL_ONE : STALL_MAX;
            end
        end
    end

endmodule

### hdl/pipeline_hazard_forwarding_unit.sv
// Top level of the pipeline hazard forwarding unit: range filter, cycle counter,
// writer chain of phfu_cell, two phfu_pick resolvers and the result register.
`timescale 1ns / 1ps

// Takes one traced instruction beat per clock while the output is not stalled
// and returns one result beat per instruction in the cycle after acceptance.
// A beat whose address lies outside [range_low, range_high] yields an all-zero
// result with accepted low and leaves the state untouched. The in-flight
// writers live in a chain of RING_DEPTH cells, youngest in cell 0; a push
// shifts every entry one cell toward the old end and drops the oldest. Each
// cell probes both source registers in parallel, and the youngest hit decides
// forwarding or stall. The cycle-count update, the ready-cycle compares in the
// cells and the priority pick form the loop that sets this rate. The result
// register takes a new beat whenever it is empty or being drained. The user
// must write registers through the plain write port (index 0 range_low, index
// 1 range_high) only while idle; the block itself does not enforce this.

module pipeline_hazard_forwarding_unit #(
    parameter int RING_DEPTH = phfu_pkg::RING_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [phfu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [phfu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // instruction beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // instr_addr[47:0], src_reg_a[57:48], src_reg_b[67:58], dest_reg[77:68], zero[79:78]
    input  logic [phfu_pkg::S_TDATA_W-1:0]    s_tdata,
    // is_branch[0], is_load[1], is_store[2]
    input  logic [phfu_pkg::S_TUSER_W-1:0]    s_tuser,
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // cycle_now[63:0], data_stall[65:64], control_stall[67:66], forwarded[68],
    // load_use[69], path_mask[74:70], zero[79:75]
    output logic [phfu_pkg::M_TDATA_W-1:0]    m_tdata,
    // accepted[0], is_memory[1]
    output logic [phfu_pkg::M_TUSER_W-1:0]    m_tuser
);
    import phfu_pkg::*;

    // Configuration registers
    logic [ADDR_W-1:0] range_low_reg;
    logic [ADDR_W-1:0] range_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RANGE_LOW:  range_low_reg  <= cfg_wdata[ADDR_W-1:0];
                REG_RANGE_HIGH: range_high_reg <= cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input beat
    logic [ADDR_W-1:0] instr_addr;
    logic [REG_W-1:0]  src_reg_a;
    logic [REG_W-1:0]  src_reg_b;
    logic [REG_W-1:0]  dest_reg;
    logic              is_branch;
    logic              is_load;
    logic              is_store;

    assign instr_addr = s_tdata[S_ADDR_LSB +: ADDR_W];
    assign src_reg_a  = s_tdata[S_SRCA_LSB +: REG_W];
    assign src_reg_b  = s_tdata[S_SRCB_LSB +: REG_W];
    assign dest_reg   = s_tdata[S_DEST_LSB +: REG_W];
    assign is_branch  = s_tuser[S_BR_BIT];
    assign is_load    = s_tuser[S_LD_BIT];
    assign is_store   = s_tuser[S_ST_BIT];

    logic in_accept;
    logic in_range;
    logic analyse;
    logic push;

    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (instr_addr >= range_low_reg) && (instr_addr <= range_high_reg);
    assign analyse   = in_accept && in_range;
    assign push      = analyse && (dest_reg != '0);

    // Cycle count kept as count+1 and count+2, the two values the cells compare
    // against once the count has taken this instruction's base cycle.
    logic [CYC_W-1:0] cnt_p1_reg;
    logic [CYC_W-1:0] cnt_p2_reg;

    // Writer chain
    entry_t [RING_DEPTH:0]   chain;
    probe_t [RING_DEPTH-1:0] probes_a;
    probe_t [RING_DEPTH-1:0] probes_b;
    src_res_t                res_a;
    src_res_t                res_b;

    logic [CYC_W-1:0] cycle_now;
    logic [CYC_W-1:0] ex_ready_new;
    logic [CYC_W-1:0] mem_ready_new;

    assign chain[0] = '{valid: 1'b1, dest: dest_reg, is_load: is_load,
                        ex_ready: ex_ready_new, mem_ready: mem_ready_new};

    for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
        phfu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (push),
            .entry_in  (chain[g]),
            .cnt_p1    (cnt_p1_reg),
            .cnt_p2    (cnt_p2_reg),
            .src_a     (src_reg_a),
            .src_b     (src_reg_b),
            .entry_out (chain[g+1]),
            .probe_a   (probes_a[g]),
            .probe_b   (probes_b[g])
        );
    end

    phfu_pick #(.DEPTH(RING_DEPTH)) u_pick_a (
        .probes   (probes_a),
        .is_store (is_store),
        .res      (res_a)
    );

    phfu_pick #(.DEPTH(RING_DEPTH)) u_pick_b (
        .probes   (probes_b),
        .is_store (is_store),
        .res      (res_b)
    );

    // Combine the two sources
    logic [4:0] path_mask;
    logic [1:0] data_stall;
    logic [1:0] control_stall;
    logic       forwarded;
    logic       load_use;
    logic [2:0] extra;

    always_comb begin
        path_mask     = res_a.path | res_b.path;
        data_stall    = (res_a.stall > res_b.stall) ? res_a.stall : res_b.stall;
        control_stall = is_branch ? BRANCH_PENALTY : STALL_NONE;
        // a branch only marks its path bit when something was forwarded
        if (is_branch && (path_mask != '0)) begin
            path_mask = path_mask | PATH_BRANCH;
        end
        forwarded = (path_mask != '0);
        load_use  = (data_stall != STALL_NONE) &&
                    ((res_a.hit && res_a.is_load) || (res_b.hit && res_b.is_load));
        extra     = {1'b0, data_stall} + {1'b0, control_stall};
    end

    // Three parallel adds off count+1: the new count and the pushed ready cycles
    assign cycle_now     = cnt_p1_reg + CYC_W'(extra);
    assign ex_ready_new  = cnt_p1_reg + CYC_W'({1'b0, extra} + 4'd1);
    assign mem_ready_new = cnt_p1_reg + CYC_W'({1'b0, extra} + 4'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_p1_reg <= CYC_W'(1);
            cnt_p2_reg <= CYC_W'(2);
        end else if (analyse) begin
            cnt_p1_reg <= ex_ready_new;
            cnt_p2_reg <= mem_ready_new;
        end
    end

    // Result register: load on every accepted beat, drop once taken
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [M_TUSER_W-1:0] m_user_reg;
    logic [M_TDATA_W-1:0] m_data_next;
    logic [M_TUSER_W-1:0] m_user_next;

    assign s_tready = !m_valid_reg || m_tready;

    always_comb begin
        m_data_next = '0;
        m_user_next = '0;
        if (in_range) begin
            m_data_next[M_CYC_LSB +: CYC_W] = cycle_now;
            m_data_next[M_DSTL_LSB +: 2]    = data_stall;
            m_data_next[M_CSTL_LSB +: 2]    = control_stall;
            m_data_next[M_FWD_BIT]          = forwarded;
            m_data_next[M_LU_BIT]           = load_use;
            m_data_next[M_PATH_LSB +: 5]    = path_mask;
            m_user_next[M_ACC_BIT]          = 1'b1;
            m_user_next[M_MEM_BIT]          = is_load || is_store;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### hdl/phfu_checker.sv
// Port-level checks on result beats of the pipeline hazard forwarding unit and
// the bind that attaches them to the top level. Uses phfu_pkg.
`timescale 1ns / 1ps

module phfu_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [phfu_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [phfu_pkg::M_TUSER_W-1:0] m_tuser
);
    import phfu_pkg::*;

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A filtered-out instruction reports nothing
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[M_ACC_BIT] |-> (m_tdata == '0) && !m_tuser[M_MEM_BIT])
        else $error("rejected instruction carries nonzero result");

    // Forwarded flag agrees with the path mask
    a_fwd_path: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_FWD_BIT] == (m_tdata[M_PATH_LSB +: 5] != 5'd0))
        else $error("forwarded flag disagrees with path mask");

    // Branch path bit only with a branch penalty and another path bit
    a_branch_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_PATH_LSB + 4] |->
            (m_tdata[M_CSTL_LSB +: 2] == BRANCH_PENALTY) &&
            (m_tdata[M_PATH_LSB +: 4] != 4'd0))
        else $error("branch path bit without branch forwarding");

    // Load-use needs a data stall
    a_load_use: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_LU_BIT] |-> m_tdata[M_DSTL_LSB +: 2] != STALL_NONE)
        else $error("load-use flagged without a data stall");

endmodule

bind pipeline_hazard_forwarding_unit phfu_checker u_phfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
